@@ rtl/core/spma_pkg.sv @@
// ----------------------------------------------------------------------------
// spma_pkg
// Shared types and codes for the sparse polynomial merge-add unit.
// ----------------------------------------------------------------------------
package spma_pkg;

    typedef logic [1:0] t_kind;

    localparam t_kind KIND_LOAD_A = 2'd0;
    localparam t_kind KIND_LOAD_B = 2'd1;
    localparam t_kind KIND_RUN    = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_a;
        logic load_b;
        logic merging;
        logic emit;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic slot_free;
        logic last;
    } t_stat;

endpackage

@@ rtl/core/spma_ctrl.sv @@
// ----------------------------------------------------------------------------
// spma_ctrl
// Controller: accepts load and run words and sequences the merge.
// ----------------------------------------------------------------------------
module spma_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  spma_pkg::t_kind   i_kind,
    input  spma_pkg::t_stat   i_stat,
    output spma_pkg::t_cmd    o_cmd
);
    import spma_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_MERGE
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   w_accept;

    assign o_in_ready = (r_state == ST_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;

    always_comb begin
        o_cmd         = '0;
        o_cmd.merging = (r_state == ST_MERGE);
        n_state       = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    case (i_kind)
                        KIND_LOAD_A: o_cmd.load_a = 1'b1;
                        KIND_LOAD_B: o_cmd.load_b = 1'b1;
                        KIND_RUN:    n_state = ST_MERGE;
                        default:     n_state = ST_IDLE;
                    endcase
                end
            end
            ST_MERGE: begin
                // One term leaves each cycle the output register can take it.
                if (i_stat.slot_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_stat.last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

@@ rtl/core/spma_dp.sv @@
// ----------------------------------------------------------------------------
// spma_dp
// Datapath: term stores, counts, merge pointers, adder and output register.
// ----------------------------------------------------------------------------
module spma_dp #(
    parameter int LIST_DEPTH = 32,
    parameter int COEF_BITS  = 16,
    parameter int EXPO_BITS  = 10
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  spma_pkg::t_cmd              i_cmd,
    output spma_pkg::t_stat             o_stat,
    input  logic signed [COEF_BITS-1:0] i_coef,
    input  logic [EXPO_BITS-1:0]        i_expo,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic signed [COEF_BITS:0]   o_sum_coef,
    output logic [EXPO_BITS-1:0]        o_term_expo,
    output logic                        o_last,
    output logic                        o_empty_res,
    output logic                        o_dropped
);
    import spma_pkg::*;

    localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int CW = $clog2(LIST_DEPTH + 1);
    localparam int SW = COEF_BITS + 1;

    logic signed [COEF_BITS-1:0] r_a_coef_mem [LIST_DEPTH];
    logic [EXPO_BITS-1:0]        r_a_expo_mem [LIST_DEPTH];
    logic signed [COEF_BITS-1:0] r_b_coef_mem [LIST_DEPTH];
    logic [EXPO_BITS-1:0]        r_b_expo_mem [LIST_DEPTH];

    logic signed [COEF_BITS-1:0] r_a_coef, r_b_coef;
    logic [EXPO_BITS-1:0]        r_a_expo, r_b_expo;

    logic [CW-1:0] r_a_cnt, r_b_cnt, n_a_cnt, n_b_cnt;
    logic [CW-1:0] r_p, r_q, n_p, n_q;
    logic          r_ovf, n_ovf;
    logic          w_a_full, w_b_full;
    logic          w_a_has, w_b_has, w_adv_a, w_adv_b, w_last, w_empty;
    logic [CW-1:0] w_p_adv, w_q_adv;
    logic [AW-1:0] w_a_raddr, w_b_raddr;
    logic signed [SW-1:0] w_a_ext, w_b_ext, w_sum;
    logic [EXPO_BITS-1:0] w_expo;

    logic                 r_out_valid;
    logic signed [SW-1:0] r_sum_coef;
    logic [EXPO_BITS-1:0] r_term_expo;
    logic                 r_last, r_empty_res, r_dropped;

    assign w_a_full = (r_a_cnt >= CW'(LIST_DEPTH));
    assign w_b_full = (r_b_cnt >= CW'(LIST_DEPTH));

    // Merge decision on the heads of both lists, read from the stores last cycle.
    assign w_a_has = (r_p < r_a_cnt);
    assign w_b_has = (r_q < r_b_cnt);
    assign w_empty = !w_a_has && !w_b_has;
    assign w_a_ext = SW'(r_a_coef);
    assign w_b_ext = SW'(r_b_coef);

    always_comb begin
        w_adv_a = 1'b0;
        w_adv_b = 1'b0;
        w_sum   = '0;
        w_expo  = '0;
        if (w_a_has && w_b_has) begin
            if (r_a_expo == r_b_expo) begin
                w_adv_a = 1'b1;
                w_adv_b = 1'b1;
                w_sum   = w_a_ext + w_b_ext;
                w_expo  = r_a_expo;
            end else if (r_a_expo > r_b_expo) begin
                w_adv_a = 1'b1;
                w_sum   = w_a_ext;
                w_expo  = r_a_expo;
            end else begin
                w_adv_b = 1'b1;
                w_sum   = w_b_ext;
                w_expo  = r_b_expo;
            end
        end else if (w_a_has) begin
            w_adv_a = 1'b1;
            w_sum   = w_a_ext;
            w_expo  = r_a_expo;
        end else if (w_b_has) begin
            w_adv_b = 1'b1;
            w_sum   = w_b_ext;
            w_expo  = r_b_expo;
        end
    end

    assign w_p_adv = r_p + CW'(w_adv_a);
    assign w_q_adv = r_q + CW'(w_adv_b);
    assign w_last  = (w_p_adv >= r_a_cnt) && (w_q_adv >= r_b_cnt);

    assign o_stat.slot_free = !r_out_valid || i_out_ready;
    assign o_stat.last      = w_last;

    always_comb begin
        n_p     = r_p;
        n_q     = r_q;
        n_a_cnt = r_a_cnt;
        n_b_cnt = r_b_cnt;
        n_ovf   = r_ovf;
        if (i_cmd.load_a) begin
            if (w_a_full) begin
                n_ovf = 1'b1;
            end else begin
                n_a_cnt = r_a_cnt + CW'(1);
            end
        end
        if (i_cmd.load_b) begin
            if (w_b_full) begin
                n_ovf = 1'b1;
            end else begin
                n_b_cnt = r_b_cnt + CW'(1);
            end
        end
        if (i_cmd.emit) begin
            if (w_last) begin
                n_p     = '0;
                n_q     = '0;
                n_a_cnt = '0;
                n_b_cnt = '0;
                n_ovf   = 1'b0;
            end else begin
                n_p = w_p_adv;
                n_q = w_q_adv;
            end
        end
    end

    // Outside a merge the stores are read at entry zero, so the heads are ready
    // as soon as a run word is taken.
    assign w_a_raddr = i_cmd.merging ? n_p[AW-1:0] : '0;
    assign w_b_raddr = i_cmd.merging ? n_q[AW-1:0] : '0;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_a && !w_a_full) begin
            r_a_coef_mem[r_a_cnt[AW-1:0]] <= i_coef;
            r_a_expo_mem[r_a_cnt[AW-1:0]] <= i_expo;
        end
        if (i_cmd.load_b && !w_b_full) begin
            r_b_coef_mem[r_b_cnt[AW-1:0]] <= i_coef;
            r_b_expo_mem[r_b_cnt[AW-1:0]] <= i_expo;
        end
        r_a_coef <= r_a_coef_mem[w_a_raddr];
        r_a_expo <= r_a_expo_mem[w_a_raddr];
        r_b_coef <= r_b_coef_mem[w_b_raddr];
        r_b_expo <= r_b_expo_mem[w_b_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p         <= '0;
            r_q         <= '0;
            r_a_cnt     <= '0;
            r_b_cnt     <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_p     <= n_p;
            r_q     <= n_q;
            r_a_cnt <= n_a_cnt;
            r_b_cnt <= n_b_cnt;
            r_ovf   <= n_ovf;
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_sum_coef  <= w_sum;
            r_term_expo <= w_expo;
            r_last      <= w_last;
            r_empty_res <= w_empty;
            r_dropped   <= r_ovf;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_sum_coef  = r_sum_coef;
    assign o_term_expo = r_term_expo;
    assign o_last      = r_last;
    assign o_empty_res = r_empty_res;
    assign o_dropped   = r_dropped;

endmodule

@@ rtl/core/sparse_polynomial_merge_add_unit.sv @@
// ----------------------------------------------------------------------------
// sparse_polynomial_merge_add_unit
// Adds two sparse polynomials held as term lists in descending exponent order.
// ----------------------------------------------------------------------------
// A load word appends its term to the first or second list; a load into a full
// list is discarded and sets the dropped flag on every term of the next run. A
// run word starts a two-pointer merge that sends one result word per cycle while
// the output side keeps up; each term store has a single read port. Terms with
// equal exponents leave as one summed term, zero sums included; a run over two
// empty lists sends a single word with empty_res and last set. New words are
// not taken while a merge is in progress, and a run empties both lists.
module sparse_polynomial_merge_add_unit #(
    parameter int LIST_DEPTH = 32,
    parameter int COEF_BITS  = 16,
    parameter int EXPO_BITS  = 10
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  spma_pkg::t_kind             i_kind,
    input  logic signed [COEF_BITS-1:0] i_coef,
    input  logic [EXPO_BITS-1:0]        i_expo,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic signed [COEF_BITS:0]   o_sum_coef,
    output logic [EXPO_BITS-1:0]        o_term_expo,
    output logic                        o_last,
    output logic                        o_empty_res,
    output logic                        o_dropped
);
    import spma_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    spma_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_kind     (i_kind),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    spma_dp #(
        .LIST_DEPTH (LIST_DEPTH),
        .COEF_BITS  (COEF_BITS),
        .EXPO_BITS  (EXPO_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_coef      (i_coef),
        .i_expo      (i_expo),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_sum_coef  (o_sum_coef),
        .o_term_expo (o_term_expo),
        .o_last      (o_last),
        .o_empty_res (o_empty_res),
        .o_dropped   (o_dropped)
    );

    // Loads and merge steps never coincide.
    a_cmd_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({w_cmd.load_a, w_cmd.load_b, w_cmd.emit}))
        else $error("load and merge commands overlap");

    // An accepted run closes the input side for the following cycle.
    a_run_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_kind == KIND_RUN) |=> !o_in_ready)
        else $error("input taken during a merge");

    // The empty-lists word is the whole run and carries zero term fields.
    a_empty_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_empty_res) |->
            (o_last && o_sum_coef == '0 && o_term_expo == '0))
        else $error("malformed empty result word");

endmodule

@@ dv/sparse_polynomial_merge_add_unit_tb.sv @@
// ----------------------------------------------------------------------------
// sparse_polynomial_merge_add_unit_tb
// Self-checking bench for the sparse polynomial merge-add unit. Term lists are
// loaded and merged through the valid/ready input, and a scoreboard keeps its
// own copy of both lists. It predicts every merged term and checks each output
// word in order. Both sides stall at random, the output side once holds off
// long enough to back up the input, and the sender drains the unit once between runs.
// ----------------------------------------------------------------------------
module sparse_polynomial_merge_add_unit_tb;

    import spma_pkg::*;

    localparam int LIST_DEPTH      = 32;
    localparam int COEF_W          = 16;
    localparam int EXPO_W          = 10;
    localparam int TOTAL_WORDS     = 460;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int SETTLE_CYCLES   = 40;

    // The one kind code that the unit ignores.
    localparam t_kind KIND_UNUSED = 2'd3;

    typedef struct {
        logic signed [COEF_W:0] coef;
        logic [EXPO_W-1:0]      expo;
        logic                   last;
        logic                   empty;
        logic                   dropped;
    } poly_term_t;

    class merge_add_scoreboard;
        logic signed [COEF_W-1:0] a_coef [LIST_DEPTH];
        logic [EXPO_W-1:0]        a_expo [LIST_DEPTH];
        logic signed [COEF_W-1:0] b_coef [LIST_DEPTH];
        logic [EXPO_W-1:0]        b_expo [LIST_DEPTH];
        int                       a_count;
        int                       b_count;
        bit                       overflow;
        poly_term_t               pending_terms [$];
        int                       mismatches;
        int                       runs;
        int                       empty_runs;
        int                       dropped_runs;
        int                       terms_checked;

        function void push_term(logic signed [COEF_W:0] coef, logic [EXPO_W-1:0] expo);
            poly_term_t t;
            t.coef    = coef;
            t.expo    = expo;
            t.last    = 1'b0;
            t.empty   = 1'b0;
            t.dropped = overflow;
            pending_terms.push_back(t);
        endfunction

        // Two-pointer merge of both lists, exactly as loaded, sorted or not.
        function void merge_lists();
            int                     p;
            int                     q;
            logic signed [COEF_W:0] s;
            p = 0;
            q = 0;
            runs++;
            if (overflow) dropped_runs++;
            if (a_count == 0 && b_count == 0) begin
                push_term('0, '0);
                pending_terms[pending_terms.size()-1].empty = 1'b1;
                empty_runs++;
            end else begin
                while (p < a_count && q < b_count) begin
                    if (a_expo[p] == b_expo[q]) begin
                        s = a_coef[p] + b_coef[q];
                        push_term(s, a_expo[p]);
                        p++;
                        q++;
                    end else if (a_expo[p] > b_expo[q]) begin
                        push_term(a_coef[p], a_expo[p]);
                        p++;
                    end else begin
                        push_term(b_coef[q], b_expo[q]);
                        q++;
                    end
                end
                for (; p < a_count; p++) push_term(a_coef[p], a_expo[p]);
                for (; q < b_count; q++) push_term(b_coef[q], b_expo[q]);
            end
            pending_terms[pending_terms.size()-1].last = 1'b1;
            a_count  = 0;
            b_count  = 0;
            overflow = 1'b0;
        endfunction

        function void note_word(t_kind kind, logic signed [COEF_W-1:0] coef,
                                logic [EXPO_W-1:0] expo);
            case (kind)
                KIND_LOAD_A: begin
                    if (a_count >= LIST_DEPTH) begin
                        overflow = 1'b1;
                    end else begin
                        a_coef[a_count] = coef;
                        a_expo[a_count] = expo;
                        a_count++;
                    end
                end
                KIND_LOAD_B: begin
                    if (b_count >= LIST_DEPTH) begin
                        overflow = 1'b1;
                    end else begin
                        b_coef[b_count] = coef;
                        b_expo[b_count] = expo;
                        b_count++;
                    end
                end
                KIND_RUN: merge_lists();
                default: ;
            endcase
        endfunction

        task report_mismatch(string msg);
            $display("ERROR: %s", msg);
            mismatches++;
        endtask

        task check_term(logic signed [COEF_W:0] coef, logic [EXPO_W-1:0] expo,
                        logic last, logic empty, logic dropped);
            poly_term_t want;
            terms_checked++;
            if (pending_terms.size() == 0) begin
                report_mismatch($sformatf("word %0d (coef %0d, expo %0d) with nothing expected",
                                          terms_checked, coef, expo));
                return;
            end
            want = pending_terms.pop_front();
            if (coef !== want.coef)
                report_mismatch($sformatf("word %0d: sum_coef %0d, expected %0d",
                                          terms_checked, coef, want.coef));
            if (expo !== want.expo)
                report_mismatch($sformatf("word %0d: term_expo %0d, expected %0d",
                                          terms_checked, expo, want.expo));
            if (last !== want.last)
                report_mismatch($sformatf("word %0d: last %b, expected %b",
                                          terms_checked, last, want.last));
            if (empty !== want.empty)
                report_mismatch($sformatf("word %0d: empty_res %b, expected %b",
                                          terms_checked, empty, want.empty));
            if (dropped !== want.dropped)
                report_mismatch($sformatf("word %0d: dropped %b, expected %b",
                                          terms_checked, dropped, want.dropped));
        endtask

        function int pending();
            return pending_terms.size();
        endfunction
    endclass

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_in_valid;
    logic                     o_in_ready;
    t_kind                    i_kind;
    logic signed [COEF_W-1:0] i_coef;
    logic [EXPO_W-1:0]        i_expo;
    logic                     o_out_valid;
    logic                     i_out_ready;
    logic signed [COEF_W:0]   o_sum_coef;
    logic [EXPO_W-1:0]        o_term_expo;
    logic                     o_last;
    logic                     o_empty_res;
    logic                     o_dropped;

    bit                       calm;
    bit                       held_off;
    int                       words_sent;
    merge_add_scoreboard      sb = new;

    sparse_polynomial_merge_add_unit #(
        .LIST_DEPTH (LIST_DEPTH),
        .COEF_BITS  (COEF_W),
        .EXPO_BITS  (EXPO_W)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_kind      (i_kind),
        .i_coef      (i_coef),
        .i_expo      (i_expo),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_sum_coef  (o_sum_coef),
        .o_term_expo (o_term_expo),
        .o_last      (o_last),
        .o_empty_res (o_empty_res),
        .o_dropped   (o_dropped)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #200000;
        $display("simulation failed");
        $finish;
    end

    function automatic logic signed [COEF_W-1:0] rand_coef();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
        return COEF_W'($urandom());
    endfunction

    function automatic logic [EXPO_W-1:0] rand_expo();
        return EXPO_W'($urandom_range(0, 1023));
    endfunction

    // Offers one word, possibly after a short gap, and waits for it to be taken.
    task automatic send_word(input t_kind kind, input logic signed [COEF_W-1:0] coef,
                             input logic [EXPO_W-1:0] expo);
        int gap;
        @(negedge i_clk);
        if (!calm && $urandom_range(0, 99) < 8) begin
            gap = $urandom_range(1, 4);
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_kind     = kind;
        i_coef     = coef;
        i_expo     = expo;
        i_in_valid = 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_word(kind, coef, expo);
        if (kind != KIND_UNUSED) words_sent++;
    endtask

    task automatic wait_for_results();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Builds one term list; sorted lists step downwards from nearby tops so
    // that the two lists often meet on the same exponent.
    function automatic void build_list(input int count, input int top, input bit sorted,
                                       output logic [EXPO_W-1:0] ex[$],
                                       output logic signed [COEF_W-1:0] cf[$]);
        int e;
        e = top;
        for (int i = 0; i < count; i++) begin
            if (sorted && e < 0) break;
            ex.push_back(sorted ? EXPO_W'(e) : rand_expo());
            cf.push_back(rand_coef());
            e -= $urandom_range(1, 4);
        end
    endfunction

    task automatic send_random_set();
        logic [EXPO_W-1:0]        a_ex [$];
        logic [EXPO_W-1:0]        b_ex [$];
        logic signed [COEF_W-1:0] a_cf [$];
        logic signed [COEF_W-1:0] b_cf [$];
        int                       mode;
        int                       na;
        int                       nb;
        int                       top;
        int                       top_b;
        bit                       sorted;
        mode = $urandom_range(0, 99);
        if (mode < 6) begin
            // Loose words of any kind, runs included.
            repeat ($urandom_range(1, 5))
                send_word(t_kind'($urandom_range(0, 3)), rand_coef(), rand_expo());
            return;
        end
        sorted = (mode >= 18);
        if (mode >= 18 && mode < 30) begin
            // Long lists, often past the depth so that terms are dropped.
            na  = $urandom_range(24, 38);
            nb  = $urandom_range(0, 38);
            top = $urandom_range(700, 1023);
        end else begin
            na  = $urandom_range(0, 8);
            nb  = $urandom_range(0, 8);
            top = $urandom_range(0, 1023);
        end
        top_b = top + $urandom_range(0, 2);
        if (top_b > 1023) top_b = 1023;
        build_list(na, top, sorted, a_ex, a_cf);
        build_list(nb, top_b, sorted, b_ex, b_cf);
        while (a_ex.size() + b_ex.size() != 0) begin
            if ($urandom_range(0, 19) == 0)
                send_word(KIND_UNUSED, rand_coef(), rand_expo());
            if (b_ex.size() == 0 || (a_ex.size() != 0 && $urandom_range(0, 1)))
                send_word(KIND_LOAD_A, a_cf.pop_front(), a_ex.pop_front());
            else
                send_word(KIND_LOAD_B, b_cf.pop_front(), b_ex.pop_front());
        end
        send_word(KIND_RUN, rand_coef(), rand_expo());
    endtask

    // Output side: random back-pressure, with one long hold-off that lets the
    // unit fill up and stall its input.
    initial begin
        i_out_ready = 1'b0;
        held_off    = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (!held_off && sb.terms_checked >= 100) begin
                held_off    = 1'b1;
                i_out_ready = 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge i_clk);
            end
            i_out_ready = calm || ($urandom_range(0, 99) >= 8);
            @(posedge i_clk);
            if (o_out_valid && i_out_ready)
                sb.check_term(o_sum_coef, o_term_expo, o_last, o_empty_res, o_dropped);
        end
    end

    initial begin
        bit drained;
        drained    = 1'b0;
        calm       = 1'b0;
        words_sent = 0;
        i_in_valid = 1'b0;
        i_kind     = KIND_LOAD_A;
        i_coef     = '0;
        i_expo     = '0;
        i_rst_n    = 1'b0;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        // A run over two empty lists.
        send_word(KIND_RUN, 16'sd0, 10'd0);
        // Coefficient and exponent extremes, a zero sum and an ignored kind.
        send_word(KIND_LOAD_A, 16'sh7FFF, 10'd1023);
        send_word(KIND_LOAD_A, 16'sh8000, 10'd512);
        send_word(KIND_LOAD_A, 16'sd5, 10'd0);
        send_word(KIND_LOAD_B, 16'sh7FFF, 10'd1023);
        send_word(KIND_LOAD_B, 16'sd100, 10'd700);
        send_word(KIND_LOAD_B, -16'sd5, 10'd0);
        send_word(KIND_UNUSED, -16'sd1, 10'd1023);
        send_word(KIND_RUN, 16'sd0, 10'd0);
        // The most negative sum.
        send_word(KIND_LOAD_A, 16'sh8000, 10'd300);
        send_word(KIND_LOAD_B, 16'sh8000, 10'd300);
        send_word(KIND_RUN, -16'sd1, 10'd1023);
        // Only one list holds terms.
        send_word(KIND_LOAD_A, 16'sd1, 10'd3);
        send_word(KIND_LOAD_A, 16'sd2, 10'd1);
        send_word(KIND_RUN, 16'sd0, 10'd0);
        send_word(KIND_LOAD_B, -16'sd1, 10'd1023);
        send_word(KIND_RUN, 16'sd0, 10'd0);
        // Lists out of order are merged without any check.
        send_word(KIND_LOAD_A, 16'sd1, 10'd5);
        send_word(KIND_LOAD_A, 16'sd2, 10'd9);
        send_word(KIND_LOAD_B, 16'sd3, 10'd7);
        send_word(KIND_LOAD_B, 16'sd4, 10'd5);
        send_word(KIND_RUN, 16'sd0, 10'd0);
        wait_for_results();

        while (words_sent < TOTAL_WORDS) begin
            calm = (words_sent >= 250 && words_sent < 340);
            if (!drained && words_sent >= 150) begin
                wait_for_results();
                drained = 1'b1;
            end
            send_random_set();
        end
        calm = 1'b0;
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Merged %0d runs from %0d words: %0d over empty lists, %0d with dropped terms.",
                 sb.runs, words_sent, sb.empty_runs, sb.dropped_runs);
        $display("Checked %0d result words across random stalls and a %0d-cycle output hold-off.",
                 sb.terms_checked, HOLD_OFF_CYCLES);
        if (sb.mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/core/spma_pkg.sv
rtl/core/spma_ctrl.sv
rtl/core/spma_dp.sv
rtl/core/sparse_polynomial_merge_add_unit.sv
dv/sparse_polynomial_merge_add_unit_tb.sv
